>>> hw/rtl/ise_pkg.sv
// Package for the integer stack engine: command and status codes, controller
// states and the command and status structs between controller and datapath.
// Depends on nothing; the controller, datapath and top level refer to it.
`default_nettype none

package ise_pkg;

  // Command codes carried in each input word.
  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_SWAP = 3'd3,
    CMD_DUMP = 3'd4
  } cmd_e;

  // Status codes returned with each result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_PEEK,
    S_SWAP_RD1,
    S_SWAP_RD2,
    S_SWAP_WR1,
    S_SWAP_WR2,
    S_DUMP
  } state_e;

  // Read address selection.
  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_PTR
  } rd_sel_e;

  // Write address and data selection.
  typedef enum logic [1:0] {
    WR_PUSH,
    WR_TOP,
    WR_SECOND
  } wr_sel_e;

  // Entry count update.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Per-cycle command from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    tmp_load;
    cnt_op_e cnt_op;
    logic    ptr_dec;
    logic    res_valid;
    status_e res_status;
    logic    res_last;
    logic    res_ram;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic short_stack;
    logic ptr_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ise_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ise_datapath.sv
// Datapath of the integer stack engine: entry count, dump pointer, swap
// holding register, the entry RAM and the result registers.
// Depends on ise_pkg and ise_ram.
`default_nettype none

module ise_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic signed [31:0]    push_value_i,
  input  wire ise_pkg::dp_cmd_t      cmd_i,
  output ise_pkg::dp_stat_t          stat_o,
  output logic                       result_valid_o,
  output logic signed [31:0]         data_value_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      ptr_q;
  logic [31:0]        push_q;
  logic [31:0]        tmp_q;
  logic               out_valid_q;
  ise_pkg::status_e   out_status_q;
  logic               out_last_q;
  logic               out_ram_q;

  logic [CW-1:0]      cnt_m1, cnt_m2;
  logic [AW-1:0]      top_addr, second_addr;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data, rd_data;

  // Addresses of the top two entries.
  assign cnt_m1      = count_q - CW'(1);
  assign cnt_m2      = count_q - CW'(2);
  assign top_addr    = cnt_m1[AW-1:0];
  assign second_addr = cnt_m2[AW-1:0];

  // Status towards the controller.
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.full        = (count_q == CW'(STACK_DEPTH));
  assign stat_o.short_stack = (count_q < CW'(2));
  assign stat_o.ptr_zero    = (ptr_q == '0);

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      ise_pkg::RD_TOP:    rd_addr = top_addr;
      ise_pkg::RD_SECOND: rd_addr = second_addr;
      ise_pkg::RD_PTR:    rd_addr = ptr_q;
      default:            rd_addr = top_addr;
    endcase
  end

  // Write address and data selection.
  always_comb begin
    case (cmd_i.wr_sel)
      ise_pkg::WR_PUSH: begin
        wr_addr = count_q[AW-1:0];
        wr_data = push_q;
      end
      ise_pkg::WR_TOP: begin
        wr_addr = top_addr;
        wr_data = rd_data;
      end
      ise_pkg::WR_SECOND: begin
        wr_addr = second_addr;
        wr_data = tmp_q;
      end
      default: begin
        wr_addr = count_q[AW-1:0];
        wr_data = push_q;
      end
    endcase
  end

  ise_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Entry count update.
  always_comb begin
    case (cmd_i.cnt_op)
      ise_pkg::CNT_INC: count_d = count_q + CW'(1);
      ise_pkg::CNT_DEC: count_d = cnt_m1;
      default:          count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Input word capture, dump pointer and swap holding register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      push_q <= push_value_i;
      ptr_q  <= top_addr;
    end else if (cmd_i.ptr_dec) begin
      ptr_q  <= ptr_q - AW'(1);
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= rd_data;
    end
  end

  // Result strobe is control state; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= cmd_i.res_status;
    out_last_q   <= cmd_i.res_last;
    out_ram_q    <= cmd_i.res_ram;
  end

  // RAM read data arrives in the same cycle as the result strobe.
  assign result_valid_o = out_valid_q;
  assign data_value_o   = (out_valid_q && out_ram_q) ? $signed(rd_data) : 32'sd0;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/ise_ctrl.sv
// Controller state machine of the integer stack engine: decodes each command
// word and sequences the datapath one step per cycle.
// Depends on ise_pkg.
`default_nettype none

module ise_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [2:0]        cmd_i,
  input  wire ise_pkg::dp_stat_t stat_i,
  output logic                   busy_o,
  output ise_pkg::dp_cmd_t       dp_o
);

  ise_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ise_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ise_pkg::S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            ise_pkg::CMD_PUSH: state_d = ise_pkg::S_PUSH;
            ise_pkg::CMD_POP:  state_d = ise_pkg::S_POP;
            ise_pkg::CMD_PEEK: state_d = ise_pkg::S_PEEK;
            ise_pkg::CMD_SWAP: state_d = ise_pkg::S_SWAP_RD1;
            ise_pkg::CMD_DUMP: state_d = stat_i.empty ? ise_pkg::S_IDLE : ise_pkg::S_DUMP;
            default:           state_d = ise_pkg::S_IDLE;
          endcase
        end
      end
      ise_pkg::S_SWAP_RD1: begin
        state_d = stat_i.short_stack ? ise_pkg::S_IDLE : ise_pkg::S_SWAP_RD2;
      end
      ise_pkg::S_SWAP_RD2: state_d = ise_pkg::S_SWAP_WR1;
      ise_pkg::S_SWAP_WR1: state_d = ise_pkg::S_SWAP_WR2;
      ise_pkg::S_DUMP: begin
        if (stat_i.ptr_zero) begin
          state_d = ise_pkg::S_IDLE;
        end
      end
      default: state_d = ise_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    dp_o.latch      = 1'b0;
    dp_o.rd_en      = 1'b0;
    dp_o.rd_sel     = ise_pkg::RD_TOP;
    dp_o.wr_en      = 1'b0;
    dp_o.wr_sel     = ise_pkg::WR_PUSH;
    dp_o.tmp_load   = 1'b0;
    dp_o.cnt_op     = ise_pkg::CNT_HOLD;
    dp_o.ptr_dec    = 1'b0;
    dp_o.res_valid  = 1'b0;
    dp_o.res_status = ise_pkg::ST_OK;
    dp_o.res_last   = 1'b1;
    dp_o.res_ram    = 1'b0;
    case (state_q)
      ise_pkg::S_IDLE: begin
        dp_o.latch = start_i;
      end
      ise_pkg::S_PUSH: begin
        dp_o.res_valid = 1'b1;
        if (stat_i.full) begin
          dp_o.res_status = ise_pkg::ST_FULL;
        end else begin
          dp_o.wr_en  = 1'b1;
          dp_o.cnt_op = ise_pkg::CNT_INC;
        end
      end
      ise_pkg::S_POP: begin
        dp_o.res_valid = 1'b1;
        if (stat_i.empty) begin
          dp_o.res_status = ise_pkg::ST_EMPTY;
        end else begin
          dp_o.cnt_op = ise_pkg::CNT_DEC;
        end
      end
      ise_pkg::S_PEEK: begin
        dp_o.res_valid = 1'b1;
        if (stat_i.empty) begin
          dp_o.res_status = ise_pkg::ST_EMPTY;
        end else begin
          dp_o.rd_en   = 1'b1;
          dp_o.res_ram = 1'b1;
        end
      end
      ise_pkg::S_SWAP_RD1: begin
        if (stat_i.short_stack) begin
          dp_o.res_valid  = 1'b1;
          dp_o.res_status = ise_pkg::ST_SHORT;
        end else begin
          dp_o.rd_en = 1'b1;
        end
      end
      // Top entry is on the read data; hold it and fetch the one below.
      ise_pkg::S_SWAP_RD2: begin
        dp_o.tmp_load = 1'b1;
        dp_o.rd_en    = 1'b1;
        dp_o.rd_sel   = ise_pkg::RD_SECOND;
      end
      ise_pkg::S_SWAP_WR1: begin
        dp_o.wr_en  = 1'b1;
        dp_o.wr_sel = ise_pkg::WR_TOP;
      end
      ise_pkg::S_SWAP_WR2: begin
        dp_o.wr_en     = 1'b1;
        dp_o.wr_sel    = ise_pkg::WR_SECOND;
        dp_o.res_valid = 1'b1;
      end
      // One entry read and one result word per cycle, top to bottom.
      ise_pkg::S_DUMP: begin
        dp_o.rd_en     = 1'b1;
        dp_o.rd_sel    = ise_pkg::RD_PTR;
        dp_o.res_valid = 1'b1;
        dp_o.res_ram   = 1'b1;
        dp_o.res_last  = stat_i.ptr_zero;
        dp_o.ptr_dec   = !stat_i.ptr_zero;
      end
      default: begin
        dp_o.latch = 1'b0;
      end
    endcase
  end

  assign busy_o = (state_q != ise_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/integer_stack_engine.sv
// Top level of the integer stack engine: controller, datapath and checks.
// Depends on ise_pkg, ise_ctrl, ise_datapath and ise_ram.
//
// Usage:
//   A command word (cmd_i, push_value_i) is taken at a rising edge where
//   start is high and busy is low. Codes: push, pop, peek, swap, dump.
//   Results appear on data_value_o, status_o and last_o for exactly one
//   cycle, marked by result_valid_o; the receiver cannot stall them.
//   Sequencing:
//     push, pop, peek: the result word is registered from the command's
//                      state, and the engine is idle when it appears.
//     swap: two reads and two writes through the one read and one write
//           port of the entry RAM; too short a stack answers at once.
//     dump: n result words on consecutive cycles for n stored entries; the
//           RAM read port sets the pace of one entry per cycle. An empty
//           stack gives no words and the engine is ready again at once.
//   Unused command codes are taken and ignored.
//   Reset clears the entry count and the controller; the entry RAM is not
//   cleared, as only written entries are ever read.
`default_nettype none

module integer_stack_engine #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         cmd_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      data_value_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);

  ise_pkg::dp_cmd_t  dp_cmd;
  ise_pkg::dp_stat_t dp_stat;

  ise_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .stat_i  (dp_stat),
    .busy_o  (busy),
    .dp_o    (dp_cmd)
  );

  ise_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_value_i   (push_value_i),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .result_valid_o (result_valid_o),
    .data_value_o   (data_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // An error status never carries a data value.
  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ise_pkg::ST_OK) |-> (data_value_o == 32'sd0))
    else $error("error status with non-zero data value");

  // Only dump words lack the last mark, and those always have status ok.
  a_notlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (status_o == ise_pkg::ST_OK))
    else $error("non-final result word with error status");

  // Dump words follow each other without gaps until the last one.
  a_dump_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> result_valid_o)
    else $error("gap inside a dump sequence");

  // While a dump is still delivering, no new command can be taken.
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("engine idle in the middle of a dump");

endmodule

`default_nettype wire
